// ===== hdl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants of the text console cursor
// Command codes, run descriptor and screen geometry used by all modules.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int unsigned COLUMNS  = 80;
    localparam int unsigned TAB_STOP = 8;
    localparam int unsigned COL_W    = 7;
    localparam int unsigned ROW_W    = 8;
    localparam int unsigned GLYPH_W  = 7;
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned MAX_RUN  = 4;
    localparam int unsigned RUN_IW   = $clog2(MAX_RUN);
    localparam int unsigned CFG_AW   = 2;
    localparam int unsigned OUT_W    = 2 + ROW_W + COL_W + GLYPH_W + 2 * COLOR_W;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HIGH  = 8'h80;

    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = GLYPH_W'(CH_SPACE);

    typedef enum logic [1:0] {
        CMD_CELL  = 2'd0,
        CMD_SHIFT = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [CFG_AW-1:0] {
        REG_TEXT_COLOR  = 2'd0,
        REG_BACK_COLOR  = 2'd1,
        REG_ROW_COUNT   = 2'd2,
        REG_SCROLL_MODE = 2'd3
    } t_reg;

    // One slot of a run: what the emitter puts out at that step.
    typedef enum logic [2:0] {
        K_CELL   = 3'd0,  // newline blank or printable write at the old cursor
        K_SHIFT  = 3'd1,
        K_CLEAR  = 3'd2,
        K_HOME   = 3'd3,  // inverted cursor at row 0, column 0
        K_CURSOR = 3'd4   // inverted cursor at the new position
    } t_kind;

    typedef struct packed {
        t_kind [MAX_RUN-1:0]  kinds;
        logic  [RUN_IW-1:0]   last_idx;
        logic  [ROW_W-1:0]    old_row;
        logic  [COL_W-1:0]    old_col;
        logic  [GLYPH_W-1:0]  glyph;
        logic  [ROW_W-1:0]    new_row;
        logic  [COL_W-1:0]    new_col;
    } t_run;

endpackage

// ===== hdl/text_console_cursor_top.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_top: character console cursor controller
// Takes character bytes, tracks the cursor and streams display commands.
// ----------------------------------------------------------------------------
// Each byte produces a run of 1 to 4 display command words, the final one
// marked with tlast; words leave the output register at one per cycle while
// the output is not stalled, and the next byte is taken while the current run
// drains. The byte passes from the input register to the run register, and
// the first word of its run from the run register to the output register.
// Write the configuration registers only while no run is pending.
module text_console_cursor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [tcc_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [tcc_pkg::COLOR_W-1:0]   i_cfg_wdata,
    // character input
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] char_byte
    // command output
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [1:0] command, [9:2] cell_row, [16:10] cell_col, [23:17] glyph_code,
    // [55:24] fore, [87:56] back
    output logic [tcc_pkg::OUT_W-1:0]     o_m_axis_tdata,
    output logic                          o_m_axis_tlast  // last
);
    import tcc_pkg::*;

    logic [COLOR_W-1:0] r_text_color;
    logic [COLOR_W-1:0] r_back_color;
    logic [ROW_W-1:0]   r_row_count;
    logic               r_scroll_mode;
    logic [COL_W-1:0]   r_cur_col;
    logic [ROW_W-1:0]   r_cur_row;
    logic               r_in_valid;
    logic [7:0]         r_in_byte;

    t_run               run;
    logic               run_take;
    logic               load;
    logic               s_accept;

    assign load            = r_in_valid && run_take;
    assign o_s_axis_tready = !r_in_valid || load;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color  <= COLOR_W'(15);
            r_back_color  <= '0;
            r_row_count   <= ROW_W'(25);
            r_scroll_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_addr))
                REG_TEXT_COLOR:  r_text_color  <= i_cfg_wdata;
                REG_BACK_COLOR:  r_back_color  <= i_cfg_wdata;
                REG_ROW_COUNT:   r_row_count   <= i_cfg_wdata[ROW_W-1:0];
                REG_SCROLL_MODE: r_scroll_mode <= i_cfg_wdata[0];
                default: begin
                    r_scroll_mode <= r_scroll_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cur_col  <= '0;
            r_cur_row  <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            // advance the cursor as the run is handed to the emitter
            if (load) begin
                r_cur_col <= run.new_col;
                r_cur_row <= run.new_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    tcc_plan u_plan (
        .i_char        (r_in_byte),
        .i_col         (r_cur_col),
        .i_row         (r_cur_row),
        .i_row_count   (r_row_count),
        .i_scroll_mode (r_scroll_mode),
        .o_run         (run)
    );

    tcc_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_run        (run),
        .o_take       (run_take),
        .i_text_color (r_text_color),
        .i_back_color (r_back_color),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_col_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col < COL_W'(COLUMNS))
        else $error("cursor column off screen");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !load |=> r_in_valid && $stable(r_in_byte))
        else $error("pending byte lost before hand-off");

    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_cur_col) && $stable(r_cur_row))
        else $error("cursor moved without a run hand-off");
`endif

endmodule

// ===== hdl/tcc_plan.sv =====
// ----------------------------------------------------------------------------
// tcc_plan: cursor step logic
// Turns one character and the cursor position into a run descriptor and
// the next cursor position.
// ----------------------------------------------------------------------------
module tcc_plan (
    input  logic [7:0]                  i_char,
    input  logic [tcc_pkg::COL_W-1:0]   i_col,
    input  logic [tcc_pkg::ROW_W-1:0]   i_row,
    input  logic [tcc_pkg::ROW_W-1:0]   i_row_count,
    input  logic                        i_scroll_mode,
    output tcc_pkg::t_run               o_run
);
    import tcc_pkg::*;

    logic [ROW_W-1:0]   rows;
    logic               is_nl;
    logic               is_pr;
    logic [COL_W:0]     c1;
    logic [ROW_W:0]     r1;
    logic               wrap;
    logic               act;
    logic [RUN_IW-1:0]  p;

    assign rows  = (i_row_count == '0) ? ROW_W'(1) : i_row_count;
    assign is_nl = (i_char == CH_NL);
    assign is_pr = (i_char >= CH_SPACE) && (i_char < CH_HIGH);

    always_comb begin
        c1 = {1'b0, i_col};
        r1 = {1'b0, i_row};
        if (i_char == CH_BS && i_col != '0) begin
            c1 = c1 - (COL_W+1)'(1);
        end else if (i_char == CH_TAB) begin
            c1 = (c1 + (COL_W+1)'(TAB_STOP)) & ~(COL_W+1)'(TAB_STOP - 1);
        end else if (is_nl) begin
            c1 = '0;
            r1 = r1 + (ROW_W+1)'(1);
        end
        if (is_pr) begin
            c1 = c1 + (COL_W+1)'(1);
        end
        wrap = (c1 >= (COL_W+1)'(COLUMNS));
        if (wrap) begin
            c1 = '0;
            r1 = r1 + (ROW_W+1)'(1);
        end
        act = (r1 >= {1'b0, rows});
        if (act) begin
            if (i_scroll_mode) begin
                r1 = {1'b0, rows} - (ROW_W+1)'(1);
            end else begin
                r1 = '0;
                c1 = '0;
            end
        end

        // fill the run slots in emission order
        for (int i = 0; i < MAX_RUN; i++) begin
            o_run.kinds[i] = K_CURSOR;
        end
        p = '0;
        if (is_nl || is_pr) begin
            o_run.kinds[p] = K_CELL;
            p = p + RUN_IW'(1);
        end
        if (act) begin
            if (i_scroll_mode) begin
                o_run.kinds[p] = K_SHIFT;
                p = p + RUN_IW'(1);
            end else begin
                o_run.kinds[p] = K_CLEAR;
                p = p + RUN_IW'(1);
                o_run.kinds[p] = K_HOME;
                p = p + RUN_IW'(1);
            end
        end
        o_run.kinds[p]  = K_CURSOR;
        o_run.last_idx  = p;
        o_run.old_row   = i_row;
        o_run.old_col   = i_col;
        o_run.glyph     = is_nl ? GLYPH_SPACE : i_char[GLYPH_W-1:0];
        o_run.new_row   = r1[ROW_W-1:0];
        o_run.new_col   = c1[COL_W-1:0];
    end

endmodule

// ===== hdl/tcc_emit.sv =====
// ----------------------------------------------------------------------------
// tcc_emit: command emitter
// Holds one run and walks its slots into the output register, one command
// word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tcc_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  tcc_pkg::t_run                 i_run,
    output logic                          o_take,
    input  logic [tcc_pkg::COLOR_W-1:0]   i_text_color,
    input  logic [tcc_pkg::COLOR_W-1:0]   i_back_color,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcc_pkg::OUT_W-1:0]     o_data,
    output logic                          o_last
);
    import tcc_pkg::*;

    t_run               r_run;
    logic               r_run_valid;
    logic [RUN_IW-1:0]  r_idx;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_last;

    logic               out_ready;
    logic               step;
    logic               step_last;
    t_kind              kind;
    t_cmd               n_cmd;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    logic [GLYPH_W-1:0] n_glyph;
    logic [COLOR_W-1:0] n_fore;
    logic [COLOR_W-1:0] n_back;

    assign out_ready = !r_out_valid || i_ready;
    assign step      = r_run_valid && out_ready;
    assign step_last = step && (r_idx == r_run.last_idx);
    assign o_take    = !r_run_valid || step_last;
    assign kind      = r_run.kinds[r_idx];

    always_comb begin
        n_cmd   = CMD_CELL;
        n_row   = '0;
        n_col   = '0;
        n_glyph = GLYPH_SPACE;
        n_fore  = i_text_color;
        n_back  = i_back_color;
        case (kind)
            K_CELL: begin
                n_row   = r_run.old_row;
                n_col   = r_run.old_col;
                n_glyph = r_run.glyph;
            end
            K_SHIFT: begin
                n_cmd = CMD_SHIFT;
            end
            K_CLEAR: begin
                n_cmd = CMD_CLEAR;
            end
            K_HOME: begin
                n_fore = i_back_color;
                n_back = i_text_color;
            end
            K_CURSOR: begin
                n_row  = r_run.new_row;
                n_col  = r_run.new_col;
                n_fore = i_back_color;
                n_back = i_text_color;
            end
            default: begin
                n_cmd = CMD_CELL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_run_valid <= 1'b1;
                r_idx       <= '0;
            end else if (step_last) begin
                r_run_valid <= 1'b0;
            end else if (step) begin
                r_idx <= r_idx + RUN_IW'(1);
            end
            if (out_ready) begin
                r_out_valid <= r_run_valid;
            end
        end
    end

    // payload: hold while the word waits downstream
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
        if (step) begin
            r_out_data <= {n_back, n_fore, n_glyph, n_col, n_row, n_cmd};
            r_out_last <= (r_idx == r_run.last_idx);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

// ===== verif/console_cmd_checker.sv =====
// ----------------------------------------------------------------------------
// console_cmd_checker: display command predictor and comparator
// Watches the config port and both streams of the text console cursor,
// tracks the cursor and colors on its own, predicts the command words each
// accepted character causes and compares every output word with them in order.
// ----------------------------------------------------------------------------
module console_cmd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tcc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [tcc_pkg::COLOR_W-1:0] i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    input  logic                        i_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,
    input  logic                        i_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [tcc_pkg::OUT_W-1:0]   i_m_axis_tdata,
    input  logic                        i_m_axis_tlast,
    output int unsigned                 o_mismatches,
    output int unsigned                 o_outstanding
);
    import tcc_pkg::*;

    localparam int unsigned ROW_LSB   = 2;
    localparam int unsigned COL_LSB   = ROW_LSB + ROW_W;
    localparam int unsigned GLYPH_LSB = COL_LSB + COL_W;
    localparam int unsigned FORE_LSB  = GLYPH_LSB + GLYPH_W;
    localparam int unsigned BACK_LSB  = FORE_LSB + COLOR_W;
    localparam int unsigned REPORT_MAX = 10;

    typedef struct {
        t_cmd               cmd;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [GLYPH_W-1:0] glyph;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic               last;
    } t_disp_cmd;

    t_disp_cmd          cmd_expect_q[$];
    logic [COLOR_W-1:0] text_rgb;
    logic [COLOR_W-1:0] back_rgb;
    logic [ROW_W-1:0]   screen_rows;
    logic               shift_on_overflow;
    int unsigned        pred_col;
    int unsigned        pred_row;
    int unsigned        mismatch_cnt;
    t_disp_cmd          want;
    logic [1:0]         got_cmd;
    logic [ROW_W-1:0]   got_row;
    logic [COL_W-1:0]   got_col;
    logic [GLYPH_W-1:0] got_glyph;
    logic [COLOR_W-1:0] got_fore;
    logic [COLOR_W-1:0] got_back;

    function automatic t_disp_cmd make_cmd(input t_cmd c, input int unsigned r,
                                           input int unsigned x,
                                           input logic [GLYPH_W-1:0] g,
                                           input logic [COLOR_W-1:0] f,
                                           input logic [COLOR_W-1:0] b);
        t_disp_cmd w;
        w.cmd   = c;
        w.row   = ROW_W'(r);
        w.col   = COL_W'(x);
        w.glyph = g;
        w.fore  = f;
        w.back  = b;
        w.last  = 1'b0;
        return w;
    endfunction

    // Move the cursor for one character and queue the words it causes.
    task automatic predict_commands(input logic [7:0] ch);
        t_disp_cmd   run[$];
        int unsigned x;
        int unsigned y;
        int unsigned rows;
        x    = pred_col;
        y    = pred_row;
        rows = (screen_rows == '0) ? 1 : screen_rows;

        if (ch == CH_BS && x != 0) begin
            x = x - 1;
        end else if (ch == CH_TAB) begin
            x = (x + TAB_STOP) & ~(TAB_STOP - 1);
        end else if (ch == CH_NL) begin
            run.push_back(make_cmd(CMD_CELL, y, x, GLYPH_SPACE, text_rgb, back_rgb));
            x = 0;
            y = y + 1;
        end

        if (ch >= CH_SPACE && ch < CH_HIGH) begin
            run.push_back(make_cmd(CMD_CELL, y, x, GLYPH_W'(ch), text_rgb, back_rgb));
            x = x + 1;
        end

        if (x >= COLUMNS) begin
            x = 0;
            y = y + 1;
        end

        if (y >= rows) begin
            if (shift_on_overflow) begin
                run.push_back(make_cmd(CMD_SHIFT, 0, 0, GLYPH_SPACE, text_rgb, back_rgb));
                y = rows - 1;
            end else begin
                run.push_back(make_cmd(CMD_CLEAR, 0, 0, GLYPH_SPACE, text_rgb, back_rgb));
                y = 0;
                x = 0;
                run.push_back(make_cmd(CMD_CELL, 0, 0, GLYPH_SPACE, back_rgb, text_rgb));
            end
        end

        // inverted cursor closes every run
        run.push_back(make_cmd(CMD_CELL, y, x, GLYPH_SPACE, back_rgb, text_rgb));
        run[run.size() - 1].last = 1'b1;
        foreach (run[i]) cmd_expect_q.push_back(run[i]);

        pred_col = x & 8'h7F;
        pred_row = y & 8'hFF;
    endtask

    task automatic count_mismatch();
        mismatch_cnt = mismatch_cnt + 1;
    endtask

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        mismatch_cnt  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            text_rgb          = 32'd15;
            back_rgb          = '0;
            screen_rows       = 8'd25;
            shift_on_overflow = 1'b0;
            pred_col          = 0;
            pred_row          = 0;
            cmd_expect_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_addr))
                    REG_TEXT_COLOR:  text_rgb          = i_cfg_wdata;
                    REG_BACK_COLOR:  back_rgb          = i_cfg_wdata;
                    REG_ROW_COUNT:   screen_rows       = i_cfg_wdata[ROW_W-1:0];
                    REG_SCROLL_MODE: shift_on_overflow = i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_cmd   = i_m_axis_tdata[1:0];
                got_row   = i_m_axis_tdata[ROW_LSB +: ROW_W];
                got_col   = i_m_axis_tdata[COL_LSB +: COL_W];
                got_glyph = i_m_axis_tdata[GLYPH_LSB +: GLYPH_W];
                got_fore  = i_m_axis_tdata[FORE_LSB +: COLOR_W];
                got_back  = i_m_axis_tdata[BACK_LSB +: COLOR_W];
                if (cmd_expect_q.size() == 0) begin
                    count_mismatch();
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $write("checker: unexpected word cmd=%0d row=%0d col=%0d",
                               got_cmd, got_row, got_col);
                        $display(" glyph=%h fore=%h back=%h last=%b",
                                 got_glyph, got_fore, got_back, i_m_axis_tlast);
                    end
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (got_cmd !== want.cmd || got_row !== want.row ||
                        got_col !== want.col || got_glyph !== want.glyph ||
                        got_fore !== want.fore || got_back !== want.back ||
                        i_m_axis_tlast !== want.last) begin
                        count_mismatch();
                        if (mismatch_cnt <= REPORT_MAX) begin
                            $write("checker: exp cmd=%0d row=%0d col=%0d",
                                   want.cmd, want.row, want.col);
                            $display(" glyph=%h fore=%h back=%h last=%b",
                                     want.glyph, want.fore, want.back, want.last);
                            $write("checker: got cmd=%0d row=%0d col=%0d",
                                   got_cmd, got_row, got_col);
                            $display(" glyph=%h fore=%h back=%h last=%b",
                                     got_glyph, got_fore, got_back, i_m_axis_tlast);
                        end
                    end
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_commands(i_s_axis_tdata);
        end
        o_outstanding <= cmd_expect_q.size();
        o_mismatches  <= mismatch_cnt;
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: text console cursor testbench
// Feeds directed and random character words under several color, row count
// and scroll settings, with random stalls on both streams and one long output
// stall; the checker predicts and compares every display command word.
// ----------------------------------------------------------------------------
module tb_top;
    import tcc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned RAND_ITEMS     = 64;
    localparam int unsigned SETTINGS_CNT   = 6;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr      = '0;
    logic [COLOR_W-1:0] i_cfg_wdata     = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata  = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic               o_m_axis_tlast;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned snd_idle_pct = 32;
    int unsigned rcv_idle_pct = 78;
    logic        hold_req     = 1'b0;
    int unsigned quiet_cycles = 0;

    // backspace at column 0, printables, high and control bytes, then ten
    // tabs that run past the last column, then a newline off the screen
    logic [7:0] opening_chars [20] = '{
        CH_BS, 8'h41, CH_BS, 8'h7F, CH_SPACE, CH_HIGH, 8'hFF, 8'h00, 8'h1F,
        CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB, CH_TAB,
        CH_TAB, CH_NL
    };

    always #5 i_clk = ~i_clk;

    text_console_cursor_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    console_cmd_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // Output side: random stalls, or one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Offer one character word, with random gaps ahead of it; tvalid stays
    // high after acceptance so that back-to-back words need no second update.
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop offering, wait for the last command word, then let the pipe settle.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                               input logic [ROW_W-1:0] rows, input logic shift_mode);
        logic [COLOR_W-1:0] vals [4];
        vals[REG_TEXT_COLOR]  = fg;
        vals[REG_BACK_COLOR]  = bg;
        vals[REG_ROW_COUNT]   = COLOR_W'(rows);
        vals[REG_SCROLL_MODE] = COLOR_W'(shift_mode);
        for (int r = REG_TEXT_COLOR; r <= REG_SCROLL_MODE; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= t_reg'(r);
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int unsigned k);
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [ROW_W-1:0]   rows;
        logic               shift_mode;
        fg         = $urandom;
        bg         = $urandom;
        rows       = ROW_W'($urandom_range(8, 2));
        shift_mode = 1'($urandom_range(1));
        case (k)
            0: begin fg = '1; bg = '0; rows = 8'd255; shift_mode = 1'b1; end
            1: begin fg = '0; bg = '1; rows = 8'd1;   shift_mode = 1'b0; end
            2: begin rows = 8'd3; shift_mode = 1'b1; end
            3: begin rows = ROW_W'($urandom_range(255, 1)); shift_mode = 1'b0; end
            5: begin rows = 8'd255; shift_mode = 1'b0; end
            default: ;
        endcase
        load_config(fg, bg, rows, shift_mode);
    endtask

    function automatic logic [7:0] pick_char();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 45)      return 8'($urandom_range(8'h7F, 8'h20));
        else if (p < 60) return CH_TAB;
        else if (p < 75) return CH_NL;
        else if (p < 85) return CH_BS;
        else             return 8'($urandom_range(255));
    endfunction

    // Mostly single random characters; now and then a long printable burst
    // so that lines wrap past the last column.
    task automatic send_random_text(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(9) == 0) begin
                burst = $urandom_range(40, 20);
                if (burst > count - sent) burst = count - sent;
                repeat (burst) send_char(8'($urandom_range(8'h7F, 8'h20)));
                sent = sent + burst;
            end else begin
                send_char(pick_char());
                sent = sent + 1;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_config('1, '0, 8'd2, 1'b0);
        foreach (opening_chars[i]) send_char(opening_chars[i]);
        wait_drained();
        load_config('1, '0, 8'd2, 1'b1);
        send_char(CH_NL);
        send_char(CH_NL);
        wait_drained();
        // zero rows with the cursor left below the screen
        load_config('0, '1, 8'd0, 1'b1);
        send_char(8'h43);
        send_char(CH_NL);
        send_char(8'hFF);

        for (int k = 0; k < SETTINGS_CNT; k++) begin
            if (k == 2) begin
                snd_idle_pct = 78;
                rcv_idle_pct = 32;
            end
            if (k == 4) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            wait_drained();
            apply_setting(k);
            if (k == 4) hold_req = 1'b1;
            send_random_text(RAND_ITEMS);
        end
        wait_drained();

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tcc_pkg.sv
hdl/tcc_plan.sv
hdl/tcc_emit.sv
hdl/text_console_cursor_top.sv
verif/console_cmd_checker.sv
verif/tb_top.sv
